// File: design/clbin_pkg.sv
package clbin_pkg;

  localparam int GRID_SIDE_MAX = 64;
  localparam int POINTS_MAX    = 1048575;

  localparam int TABLE_DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COORD_W     = (GRID_SIDE_MAX > 2) ? $clog2(GRID_SIDE_MAX) : 1;
  localparam int ROW_W       = $clog2(GRID_SIDE_MAX * GRID_SIDE_MAX);

  localparam int POS_W    = 32;
  localparam int SCALE_W  = 32;
  localparam int PROD_W   = POS_W + SCALE_W;
  localparam int FRAC_SH  = 40;
  localparam int CINT_W   = PROD_W - FRAC_SH;
  localparam int SIDE_W   = 7;
  localparam int SIDEU_W  = 9;
  localparam int PTS_W    = 20;
  localparam int CELL_W   = 18;
  localparam int FUNC_W   = 2;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 32;
  localparam int QEXT_W   = ((ADDR_W > CELL_W) ? ADDR_W : CELL_W) + 1;
  localparam int LIM_W    = 25;

  localparam logic [SIDE_W-1:0]  SIDE_RST  = SIDE_W'(64);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(16777216);
  localparam logic [PTS_W-1:0]   OBJC_RST  = PTS_W'(1048575);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_READ   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_SIDE  = 2'd0,
    REG_SCALE = 2'd1,
    REG_OBJC  = 2'd2,
    REG_NONE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] idx;
    logic              clamped;
  } cell_res_t;

endpackage

// File: design/cell_linked_list_binning.sv
// Bins 3D points into a cubic grid and keeps a head-of-list entry per cell in a head memory
// with one write port and one read port. An insert passes the scaling and indexing pipeline,
// then takes the cell index, does one memory read and one read-modify-write before the result
// strobe; a read does the memory read and then returns the entry, and an unused function code
// answers from idle without touching the memory. A clear sweeps all 262144 entries of the head
// memory, one entry a cycle, then gives its result; after reset the same sweep runs with the
// reset marker and busy stays high for the whole sweep. Results come as a one-cycle out_valid
// strobe and cannot be held off; busy drops in the cycle the strobe shows, so the next item may start then.
module cell_linked_list_binning
  import clbin_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [POS_W-1:0]    in_pos_x,
  input  logic [POS_W-1:0]    in_pos_y,
  input  logic [POS_W-1:0]    in_pos_z,
  input  logic [CELL_W-1:0]   in_query_cell,
  output logic                out_valid,
  output logic [CELL_W-1:0]   out_cell_number,
  output logic [PTS_W-1:0]    out_link_value,
  output logic [PTS_W-1:0]    out_point_number,
  output logic                out_clamped,
  output logic                out_too_many,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_RD,
    ST_WB,
    ST_CLR
  } state_t;

  state_t              st_r;
  func_t               func_r;
  logic                boot_r;
  logic [SIDE_W-1:0]   side_cfg_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [PTS_W-1:0]    objc_r;
  logic [PTS_W-1:0]    pts_r;
  logic [PTS_W-1:0]    marker_r;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [CELL_W-1:0]   q_r;
  logic                in_tab_r;
  logic                clamped_r;

  logic                accept;
  func_t               func_in;
  logic [SIDEU_W-1:0]  side_use;
  logic [LIM_W-1:0]    limit;
  logic                full;
  logic [QEXT_W-1:0]   q_ext;
  cell_res_t           calc_res;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [PTS_W-1:0]    ram_wdata, ram_rdata;

  assign busy    = (st_r != ST_IDLE);
  assign accept  = start && !busy;
  assign func_in = func_t'(in_func);
  assign q_ext   = QEXT_W'(in_query_cell);

  always_comb begin
    if (side_cfg_r == '0) begin
      side_use = SIDEU_W'(1);
    end else if (SIDEU_W'(side_cfg_r) > SIDEU_W'(GRID_SIDE_MAX)) begin
      side_use = SIDEU_W'(GRID_SIDE_MAX);
    end else begin
      side_use = SIDEU_W'(side_cfg_r);
    end
  end

  assign limit = (LIM_W'(objc_r) > LIM_W'(POINTS_MAX)) ? LIM_W'(POINTS_MAX) : LIM_W'(objc_r);
  assign full  = (LIM_W'(pts_r) >= limit);

  clbin_cell_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (accept && (func_in == FN_INSERT)),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .pos_z (in_pos_z),
    .scale (scale_r),
    .side  (side_use),
    .res   (calc_res)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = pts_r;
    ram_re    = (st_r == ST_RD);
    if (st_r == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = marker_r;
    end else if ((st_r == ST_WB) && (func_r == FN_INSERT) && !full) begin
      ram_we = 1'b1;
    end
  end

  clbin_head_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (PTS_W)
  ) u_heads (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLR;
      boot_r     <= 1'b1;
      out_valid  <= 1'b0;
      side_cfg_r <= SIDE_RST;
      scale_r    <= SCALE_RST;
      objc_r     <= OBJC_RST;
      pts_r      <= '0;
      marker_r   <= OBJC_RST;
      clr_addr_r <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          REG_SIDE:  side_cfg_r <= cfg_data[SIDE_W-1:0];
          REG_SCALE: scale_r    <= cfg_data[SCALE_W-1:0];
          REG_OBJC:  objc_r     <= cfg_data[PTS_W-1:0];
          default: ;
        endcase
      end
      unique case (st_r)
        ST_IDLE: begin
          if (accept) begin
            func_r   <= func_in;
            q_r      <= in_query_cell;
            addr_r   <= q_ext[ADDR_W-1:0];
            in_tab_r <= (q_ext < QEXT_W'(TABLE_DEPTH));
            unique case (func_in)
              FN_INSERT: st_r <= ST_CALC;
              FN_READ:   st_r <= ST_RD;
              FN_CLEAR: begin
                st_r       <= ST_CLR;
                marker_r   <= objc_r;
                pts_r      <= '0;
                clr_addr_r <= '0;
              end
              default: begin
                out_valid        <= 1'b1;
                out_cell_number  <= '0;
                out_link_value   <= '0;
                out_point_number <= '0;
                out_clamped      <= 1'b0;
                out_too_many     <= 1'b0;
              end
            endcase
          end
        end
        ST_CALC: begin
          if (calc_res.vld) begin
            addr_r    <= calc_res.idx;
            clamped_r <= calc_res.clamped;
            st_r      <= ST_RD;
          end
        end
        ST_RD: begin
          st_r <= ST_WB;
        end
        ST_WB: begin
          st_r      <= ST_IDLE;
          out_valid <= 1'b1;
          if (func_r == FN_INSERT) begin
            out_cell_number <= CELL_W'(addr_r);
            out_clamped     <= clamped_r;
            out_too_many    <= full;
            if (full) begin
              out_link_value   <= '0;
              out_point_number <= '0;
            end else begin
              out_link_value   <= ram_rdata;
              out_point_number <= pts_r;
              pts_r            <= PTS_W'(pts_r + 1'b1);
            end
          end else begin
            out_cell_number  <= q_r;
            out_link_value   <= in_tab_r ? ram_rdata : objc_r;
            out_point_number <= '0;
            out_clamped      <= 1'b0;
            out_too_many     <= 1'b0;
          end
        end
        ST_CLR: begin
          clr_addr_r <= ADDR_W'(clr_addr_r + 1'b1);
          if (clr_addr_r == ADDR_W'(TABLE_DEPTH - 1)) begin
            st_r   <= ST_IDLE;
            boot_r <= 1'b0;
            if (!boot_r) begin
              out_valid        <= 1'b1;
              out_cell_number  <= '0;
              out_link_value   <= '0;
              out_point_number <= '0;
              out_clamped      <= 1'b0;
              out_too_many     <= 1'b0;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_calc_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    calc_res.vld |-> (st_r == ST_CALC))
    else $error("cell index arrived outside the calc wait");

  a_pts_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_WB) && (func_r == FN_INSERT) && !full) |=>
      (pts_r == PTS_W'($past(pts_r) + 1'b1)))
    else $error("point count did not advance on stored insert");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((st_r == ST_WB) || (st_r == ST_CLR)))
    else $error("head memory written outside write-back or sweep");

endmodule

// File: design/clbin_head_ram.sv
module clbin_head_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/clbin_cell_calc.sv
module clbin_cell_calc
  import clbin_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [POS_W-1:0]   pos_x,
  input  logic [POS_W-1:0]   pos_y,
  input  logic [POS_W-1:0]   pos_z,
  input  logic [SCALE_W-1:0] scale,
  input  logic [SIDEU_W-1:0] side,
  output cell_res_t          res
);

  logic [3:0]          vld_r;
  logic [CINT_W-1:0]   cx_r, cy_r, cz_r;
  logic [COORD_W-1:0]  ix_r, iy_r, iz_r, iz2_r;
  logic                sat_r, sat2_r, sat3_r;
  logic [ROW_W-1:0]    row_r;
  logic [ADDR_W-1:0]   cell_r;
  logic [PROD_W-1:0]   px, py, pz;
  logic [COORD_W-1:0]  ix_nxt, iy_nxt, iz_nxt;
  logic                sx, sy, sz;

  function automatic logic [COORD_W-1:0] clip(input logic [CINT_W-1:0] c,
                                              input logic [SIDEU_W-1:0] n,
                                              output logic s);
    logic [CINT_W-1:0] n_ext;
    n_ext = CINT_W'(n);
    s = (c >= n_ext);
    return s ? COORD_W'(n - SIDEU_W'(1)) : c[COORD_W-1:0];
  endfunction

  assign px = PROD_W'(pos_x) * PROD_W'(scale);
  assign py = PROD_W'(pos_y) * PROD_W'(scale);
  assign pz = PROD_W'(pos_z) * PROD_W'(scale);

  always_comb begin
    ix_nxt = clip(cx_r, side, sx);
    iy_nxt = clip(cy_r, side, sy);
    iz_nxt = clip(cz_r, side, sz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], go};
    end
    cx_r   <= px[PROD_W-1:FRAC_SH];
    cy_r   <= py[PROD_W-1:FRAC_SH];
    cz_r   <= pz[PROD_W-1:FRAC_SH];
    ix_r   <= ix_nxt;
    iy_r   <= iy_nxt;
    iz_r   <= iz_nxt;
    sat_r  <= sx | sy | sz;
    row_r  <= ROW_W'(ROW_W'(ix_r) * ROW_W'(side) + ROW_W'(iy_r));
    iz2_r  <= iz_r;
    sat2_r <= sat_r;
    cell_r <= ADDR_W'(ADDR_W'(row_r) * ADDR_W'(side) + ADDR_W'(iz2_r));
    sat3_r <= sat2_r;
  end

  assign res.vld     = vld_r[3];
  assign res.idx     = cell_r;
  assign res.clamped = sat3_r;

endmodule

// File: verif/cell_bin_checker.sv
`timescale 1ns / 1ps
module cell_bin_checker
  import clbin_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [POS_W-1:0]   in_pos_x,
  input  logic [POS_W-1:0]   in_pos_y,
  input  logic [POS_W-1:0]   in_pos_z,
  input  logic [CELL_W-1:0]  in_query_cell,
  input  logic               out_valid,
  input  logic [CELL_W-1:0]  out_cell_number,
  input  logic [PTS_W-1:0]   out_link_value,
  input  logic [PTS_W-1:0]   out_point_number,
  input  logic               out_clamped,
  input  logic               out_too_many,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [CELL_W-1:0] cnum;
    logic [PTS_W-1:0]  link;
    logic [PTS_W-1:0]  point;
    logic              clamped;
    logic              too_many;
  } bin_result_t;

  logic [PTS_W-1:0]   heads [TABLE_DEPTH];
  logic [PTS_W-1:0]   points_stored;
  logic [SIDE_W-1:0]  side_reg;
  logic [SCALE_W-1:0] scale_reg;
  logic [PTS_W-1:0]   objc_reg;
  bin_result_t        bin_results_due [$];

  initial errors = 0;
  initial pending = 0;

  function automatic void fill_heads(logic [PTS_W-1:0] marker);
    for (int i = 0; i < TABLE_DEPTH; i++) heads[i] = marker;
  endfunction

  function automatic int unsigned grid_side();
    if (side_reg == '0) return 1;
    if (side_reg > GRID_SIDE_MAX) return GRID_SIDE_MAX;
    return int'(side_reg);
  endfunction

  // unsaturated cell coordinate: floor(pos * scale / 2^40)
  function automatic logic [CINT_W-1:0] axis_raw(logic [POS_W-1:0] pos);
    return CINT_W'((PROD_W'(pos) * PROD_W'(scale_reg)) >> FRAC_SH);
  endfunction

  function automatic bin_result_t bin_point(func_t fn, logic [POS_W-1:0] px,
                                            logic [POS_W-1:0] py, logic [POS_W-1:0] pz,
                                            logic [CELL_W-1:0] q);
    bin_result_t r;
    int unsigned n;
    int unsigned ix;
    int unsigned iy;
    int unsigned iz;
    int unsigned flat;
    logic [CINT_W-1:0] cx;
    logic [CINT_W-1:0] cy;
    logic [CINT_W-1:0] cz;
    r = '0;
    case (fn)
      FN_INSERT: begin
        n  = grid_side();
        cx = axis_raw(px);
        cy = axis_raw(py);
        cz = axis_raw(pz);
        r.clamped = (cx >= n) || (cy >= n) || (cz >= n);
        ix = (cx >= n) ? n - 1 : int'(cx);
        iy = (cy >= n) ? n - 1 : int'(cy);
        iz = (cz >= n) ? n - 1 : int'(cz);
        flat = (ix * n + iy) * n + iz;
        r.cnum = CELL_W'(flat);
        if (points_stored >= ((objc_reg > POINTS_MAX) ? POINTS_MAX : objc_reg)) begin
          r.too_many = 1'b1;
        end else begin
          r.link = heads[flat];
          r.point = points_stored;
          heads[flat] = points_stored;
          points_stored = points_stored + 1'b1;
        end
      end
      FN_READ: begin
        r.cnum = q;
        r.link = (q < TABLE_DEPTH) ? heads[q] : objc_reg;
      end
      FN_CLEAR: begin
        fill_heads(objc_reg);
        points_stored = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: mismatch in %s, expected 0x%0h, got 0x%0h", $time, what, want, got);
    errors++;
  endtask

  task automatic check_result();
    bin_result_t want;
    if (bin_results_due.size() == 0) begin
      report("result with no item due", '0, 32'(out_cell_number));
      return;
    end
    want = bin_results_due.pop_front();
    if (out_cell_number !== want.cnum)
      report("cell_number", 32'(want.cnum), 32'(out_cell_number));
    if (out_link_value !== want.link)
      report("link_value", 32'(want.link), 32'(out_link_value));
    if (out_point_number !== want.point)
      report("point_number", 32'(want.point), 32'(out_point_number));
    if (out_clamped !== want.clamped)
      report("clamped", 32'(want.clamped), 32'(out_clamped));
    if (out_too_many !== want.too_many)
      report("too_many", 32'(want.too_many), 32'(out_too_many));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      side_reg = SIDE_RST;
      scale_reg = SCALE_RST;
      objc_reg = OBJC_RST;
      points_stored = '0;
      fill_heads(OBJC_RST);
      bin_results_due.delete();
    end else begin
      if (out_valid) check_result();
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_SIDE:  side_reg = cfg_data[SIDE_W-1:0];
          REG_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
          REG_OBJC:  objc_reg = cfg_data[PTS_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        bin_results_due.push_back(bin_point(func_t'(in_func), in_pos_x, in_pos_y, in_pos_z,
                                            in_query_cell));
    end
    pending = bin_results_due.size();
  end

endmodule

// File: verif/cell_linked_list_binning_test.sv
`timescale 1ns / 1ps
module cell_linked_list_binning_test;
  import clbin_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASE_ITEMS = 150;
  localparam logic [SCALE_W-1:0] UNIT_SCALE = 32'h0100_0000;
  localparam logic [CDATA_W-1:0] OBJC_FULL = CDATA_W'(OBJC_RST);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [FUNC_W-1:0]  in_func = '0;
  logic [POS_W-1:0]   in_pos_x = '0;
  logic [POS_W-1:0]   in_pos_y = '0;
  logic [POS_W-1:0]   in_pos_z = '0;
  logic [CELL_W-1:0]  in_query_cell = '0;
  logic               out_valid;
  logic [CELL_W-1:0]  out_cell_number;
  logic [PTS_W-1:0]   out_link_value;
  logic [PTS_W-1:0]   out_point_number;
  logic               out_clamped;
  logic               out_too_many;
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;
  int                 errors;
  int                 pending;

  logic [SIDE_W-1:0]  side_now = SIDE_RST;
  logic [SCALE_W-1:0] scale_now = SCALE_RST;
  int unsigned        idle_pct = 0;
  int unsigned        cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_linked_list_binning uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_query_cell(in_query_cell),
    .out_valid(out_valid), .out_cell_number(out_cell_number),
    .out_link_value(out_link_value), .out_point_number(out_point_number),
    .out_clamped(out_clamped), .out_too_many(out_too_many),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cell_bin_checker bin_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_query_cell(in_query_cell),
    .out_valid(out_valid), .out_cell_number(out_cell_number),
    .out_link_value(out_link_value), .out_point_number(out_point_number),
    .out_clamped(out_clamped), .out_too_many(out_too_many),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned side_in_use();
    if (side_now == '0) return 1;
    if (side_now > GRID_SIDE_MAX) return GRID_SIDE_MAX;
    return int'(side_now);
  endfunction

  // mostly inside the grid, with a margin past the far edge; some extremes and noise
  function automatic logic [POS_W-1:0] pick_pos();
    longint unsigned span;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return ($urandom_range(0, 1) == 1) ? '1 : '0;
    if (r < 22 || scale_now == '0) return $urandom();
    span = (longint'(side_in_use()) << FRAC_SH) / scale_now;
    span = span + span / 8;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    return $urandom_range(0, 32'(span));
  endfunction

  function automatic logic [CELL_W-1:0] pick_query();
    int unsigned n;
    n = side_in_use();
    if ($urandom_range(0, 4) == 0) return CELL_W'($urandom());
    return CELL_W'($urandom_range(0, n * n * n - 1));
  endfunction

  task automatic send_item(func_t fn, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                           logic [POS_W-1:0] pz, logic [CELL_W-1:0] q);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_query_cell <= q;
    do @(posedge clk); while (busy);
  endtask

  task automatic put_point(logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] pz);
    send_item(FN_INSERT, px, py, pz, CELL_W'($urandom()));
  endtask

  task automatic ask_cell(logic [CELL_W-1:0] q);
    send_item(FN_READ, $urandom(), $urandom(), $urandom(), q);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CDATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SIDE) side_now = data[SIDE_W-1:0];
    if (idx == REG_SCALE) scale_now = data;
  endtask

  task automatic configure(logic [CDATA_W-1:0] side, logic [CDATA_W-1:0] scale,
                           logic [CDATA_W-1:0] objc);
    drain();
    cfg_write(REG_SIDE, side);
    cfg_write(REG_SCALE, scale);
    cfg_write(REG_OBJC, objc);
  endtask

  task automatic run_phase(int items, bit with_clear);
    int unsigned r;
    int clear_at;
    clear_at = with_clear ? $urandom_range(0, items / 4) : -1;
    for (int i = 0; i < items; i++) begin
      if (i == clear_at) send_item(FN_CLEAR, $urandom(), $urandom(), $urandom(), pick_query());
      if ($urandom_range(0, 49) == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 68) put_point(pick_pos(), pick_pos(), pick_pos());
      else if (r < 94) ask_cell(pick_query());
      else send_item(FN_NOP, $urandom(), $urandom(), $urandom(), CELL_W'($urandom()));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    drain();

    // reset settings: 64 cells a side, one cell per unit
    put_point('0, '0, '0);
    put_point('0, '0, '0);
    put_point('1, '1, '1);
    put_point(32'h003F_FFFF, 32'h0001_0000, 32'h0000_FFFF);
    ask_cell('0);
    ask_cell('1);
    ask_cell(CELL_W'(12345));
    send_item(FN_NOP, '1, '1, '1, '1);

    // side 0 behaves as 1, largest scale
    configure(0, '1, OBJC_FULL);
    put_point(32'd1, 32'd1, 32'd1);
    put_point('1, '1, '1);
    // side beyond the maximum, zero scale
    configure(127, '0, OBJC_FULL);
    put_point('1, '1, '1);
    configure(2, UNIT_SCALE, OBJC_FULL);
    put_point(32'h0001_FFFF, 32'h0002_0000, 32'h0001_0000);

    // capacity below the stored count, then marker change without a clear
    configure(64, UNIT_SCALE, 3);
    put_point($urandom(), $urandom(), $urandom());
    ask_cell(CELL_W'(99999));
    configure(64, UNIT_SCALE, 0);
    cfg_write(REG_NONE, $urandom());
    send_item(FN_CLEAR, $urandom(), $urandom(), $urandom(), '1);
    ask_cell('0);
    put_point('0, '0, '0);
    configure(64, UNIT_SCALE, 2);
    put_point(32'h0005_0000, '0, '0);
    put_point(32'h0005_8000, '0, '0);
    put_point('0, '0, '0);
    ask_cell(CELL_W'(5 * 64 * 64));
    send_item(FN_NOP, '0, '0, '0, '0);

    idle_pct = 26;
    configure(4, UNIT_SCALE, OBJC_FULL);
    run_phase(PHASE_ITEMS, 1'b0);
    configure(64, $urandom_range(32'h0040_0000, 32'h0400_0000), OBJC_FULL);
    run_phase(PHASE_ITEMS, 1'b0);

    idle_pct = 64;
    configure(127, '1, OBJC_FULL);
    run_phase(PHASE_ITEMS, 1'b0);
    configure(1, $urandom(), $urandom_range(0, 20'hFFFFF));
    cfg_write(REG_NONE, $urandom());
    run_phase(PHASE_ITEMS, 1'b0);

    idle_pct = 0;
    configure($urandom_range(2, 64), UNIT_SCALE, 60);
    run_phase(PHASE_ITEMS, 1'b1);
    configure(3, UNIT_SCALE, OBJC_FULL);
    run_phase(PHASE_ITEMS, 1'b0);

    drain();
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
